FILE: rtl/hjsq_pkg.sv
// ----------------------------------------------------------------------------
// hjsq_pkg
// shared types, codes and reset values of the hall joystick scroll qualifier
// ----------------------------------------------------------------------------
package hjsq_pkg;

  localparam int unsigned SampleBitsDefault = 10;
  localparam int unsigned TimerBitsDefault  = 16;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 10;
  localparam int unsigned HitBits     = 8;

  localparam int unsigned RestResetVal = 888;
  localparam logic [HitBits-1:0] HitMax = 8'd255;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_BUTTON = 2'd2,
    KIND_CAL    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_UP   = 2'd1,
    EV_DOWN = 2'd2
  } event_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_SLOW_INTERVAL  = 3'd0,
    REG_FAST_INTERVAL  = 3'd1,
    REG_BUTTON_HOLDOFF = 3'd2,
    REG_RAMP_HITS      = 3'd3,
    REG_UP_OFFSET      = 3'd4,
    REG_DOWN_OFFSET    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]         slow_interval;
    logic [9:0]         fast_interval;
    logic [9:0]         button_holdoff;
    logic [HitBits-1:0] ramp_hits;
    logic [9:0]         up_offset;
    logic [9:0]         down_offset;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    slow_interval:  10'd25,
    fast_interval:  10'd10,
    button_holdoff: 10'd100,
    ramp_hits:      8'd40,
    up_offset:      10'd15,
    down_offset:    10'd23
  };

endpackage

FILE: rtl/hjsq_cfg.sv
// ----------------------------------------------------------------------------
// hjsq_cfg
// configuration register file, written through the cfg channel
// ----------------------------------------------------------------------------
module hjsq_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [hjsq_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [hjsq_pkg::CfgDataBits-1:0] cfg_data_i,
  output hjsq_pkg::cfg_t                   cfg_o
);

  hjsq_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (hjsq_pkg::reg_idx_e'(cfg_index_i))
        hjsq_pkg::REG_SLOW_INTERVAL:  cfg_d.slow_interval  = cfg_data_i;
        hjsq_pkg::REG_FAST_INTERVAL:  cfg_d.fast_interval  = cfg_data_i;
        hjsq_pkg::REG_BUTTON_HOLDOFF: cfg_d.button_holdoff = cfg_data_i;
        hjsq_pkg::REG_RAMP_HITS:      cfg_d.ramp_hits = cfg_data_i[hjsq_pkg::HitBits-1:0];
        hjsq_pkg::REG_UP_OFFSET:      cfg_d.up_offset      = cfg_data_i;
        hjsq_pkg::REG_DOWN_OFFSET:    cfg_d.down_offset    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hjsq_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/hjsq_core.sv
// ----------------------------------------------------------------------------
// hjsq_core
// qualifier state and per-item decision logic, one item per cycle while acc_i accepts one
// ----------------------------------------------------------------------------
module hjsq_core #(
  parameter int unsigned SampleBits = hjsq_pkg::SampleBitsDefault,
  parameter int unsigned TimerBits  = hjsq_pkg::TimerBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hjsq_pkg::cfg_t        cfg_i,
  input  logic                  acc_i,
  input  hjsq_pkg::kind_e       kind_i,
  input  logic [SampleBits-1:0] sample_up_i,
  input  logic [SampleBits-1:0] sample_down_i,
  input  logic                  button_pressed_i,
  output hjsq_pkg::event_e      event_o,
  output logic                  fast_mode_o
);

  localparam int unsigned TimeCmpW = (TimerBits > 10) ? TimerBits : 10;
  localparam int unsigned ThrW     = (SampleBits > 10) ? SampleBits : 10;
  localparam logic [SampleBits-1:0] RestRst =
    (hjsq_pkg::RestResetVal > (2 ** SampleBits) - 1) ? {SampleBits{1'b1}}
                                                      : SampleBits'(hjsq_pkg::RestResetVal);

  logic [TimerBits-1:0]        ms_q, ms_d;
  logic [TimerBits-1:0]        last_scroll_q, last_scroll_d;
  logic [TimerBits-1:0]        last_button_q, last_button_d;
  logic                        held_q, held_d;
  logic [hjsq_pkg::HitBits-1:0] hit_q, hit_d, hit_inc;
  logic [SampleBits-1:0]       rest_up_q, rest_up_d;
  logic [SampleBits-1:0]       rest_down_q, rest_down_d;

  logic [TimerBits-1:0] el_button, el_scroll;
  logic [9:0]           interval;
  logic                 qualified;
  logic [ThrW-1:0]      rest_up_w, rest_down_w, off_up_w, off_down_w;
  logic [ThrW-1:0]      thr_up, thr_down;
  logic                 hit_up, hit_down;
  hjsq_pkg::event_e     event_d;

  assign el_button = ms_q - last_button_q;
  assign el_scroll = ms_q - last_scroll_q;
  assign interval  = (hit_q > cfg_i.ramp_hits) ? cfg_i.fast_interval : cfg_i.slow_interval;
  assign qualified = !held_q &&
                     (TimeCmpW'(el_button) >= TimeCmpW'(cfg_i.button_holdoff)) &&
                     (TimeCmpW'(el_scroll) >= TimeCmpW'(interval));

  assign rest_up_w   = ThrW'(rest_up_q);
  assign rest_down_w = ThrW'(rest_down_q);
  assign off_up_w    = ThrW'(cfg_i.up_offset);
  assign off_down_w  = ThrW'(cfg_i.down_offset);
  assign thr_up      = (off_up_w >= rest_up_w) ? '0 : rest_up_w - off_up_w;
  assign thr_down    = (off_down_w >= rest_down_w) ? '0 : rest_down_w - off_down_w;
  assign hit_up      = ThrW'(sample_up_i) < thr_up;
  assign hit_down    = ThrW'(sample_down_i) < thr_down;
  assign hit_inc     = (hit_q < hjsq_pkg::HitMax) ? hit_q + 1'b1 : hit_q;

  always_comb begin
    ms_d          = ms_q;
    last_scroll_d = last_scroll_q;
    last_button_d = last_button_q;
    held_d        = held_q;
    hit_d         = hit_q;
    rest_up_d     = rest_up_q;
    rest_down_d   = rest_down_q;
    event_d       = hjsq_pkg::EV_NONE;
    if (acc_i) begin
      case (kind_i)
        hjsq_pkg::KIND_TICK: begin
          ms_d = ms_q + 1'b1;
        end
        hjsq_pkg::KIND_BUTTON: begin
          last_button_d = ms_q;
          held_d        = button_pressed_i;
        end
        hjsq_pkg::KIND_CAL: begin
          if (sample_up_i < rest_up_q) rest_up_d = sample_up_i;
          if (sample_down_i < rest_down_q) rest_down_d = sample_down_i;
        end
        hjsq_pkg::KIND_POLL: begin
          if (qualified) begin
            last_scroll_d = ms_q;
            if (hit_up) begin
              event_d = hjsq_pkg::EV_UP;
              hit_d   = hit_inc;
            end else if (hit_down) begin
              event_d = hjsq_pkg::EV_DOWN;
              hit_d   = hit_inc;
            end else begin
              hit_d = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q          <= '0;
      last_scroll_q <= '0;
      last_button_q <= '0;
      held_q        <= 1'b0;
      hit_q         <= '0;
      rest_up_q     <= RestRst;
      rest_down_q   <= RestRst;
    end else begin
      ms_q          <= ms_d;
      last_scroll_q <= last_scroll_d;
      last_button_q <= last_button_d;
      held_q        <= held_d;
      hit_q         <= hit_d;
      rest_up_q     <= rest_up_d;
      rest_down_q   <= rest_down_d;
    end
  end

  assign event_o     = event_d;
  assign fast_mode_o = hit_d > cfg_i.ramp_hits;

  a_event_only_on_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_d != hjsq_pkg::EV_NONE) |-> (acc_i && kind_i == hjsq_pkg::KIND_POLL))
    else $error("scroll event on a non-poll item");

  a_event_counts_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_d != hjsq_pkg::EV_NONE) |=> (hit_q != '0 && last_scroll_q == $past(ms_q)))
    else $error("scroll event did not update hit count or scroll time");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && kind_i == hjsq_pkg::KIND_TICK) |=> (ms_q == $past(ms_q) + 1'b1))
    else $error("tick did not advance timer");

  a_held_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> (event_d == hjsq_pkg::EV_NONE))
    else $error("scroll event while button held");

endmodule

FILE: rtl/hall_joystick_scroll_qualifier_top.sv
// ----------------------------------------------------------------------------
// hall_joystick_scroll_qualifier_top
// turns hall sensor items into rate-limited scroll up/down events
// ----------------------------------------------------------------------------
// Every input item (tick, poll, button change, calibration sample) yields
// exactly one result item in the cycle after it is accepted. One item is taken
// per clock: the state update and the decision are a single combinational
// pass into the output register, and a new item is accepted whenever that
// register is empty or being drained in the same cycle. Configuration writes
// are always accepted and should be issued only while no items are in flight.
module hall_joystick_scroll_qualifier_top #(
  parameter int unsigned SampleBits = hjsq_pkg::SampleBitsDefault,
  parameter int unsigned TimerBits  = hjsq_pkg::TimerBitsDefault,
  localparam int unsigned InDataW   = ((2 * SampleBits + 1 + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hjsq_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [hjsq_pkg::CfgDataBits-1:0] cfg_data_i,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [InDataW-1:0]               s_axis_tdata,  // sample_up, sample_down, button_pressed
  input  logic [1:0]                       s_axis_tuser,  // kind
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata   // scroll_event, fast_mode
);

  hjsq_pkg::cfg_t   cfg;
  hjsq_pkg::event_e ev_d;
  logic             fast_d;
  logic             acc;
  logic             out_valid_q, out_valid_d;
  hjsq_pkg::event_e ev_q;
  logic             fast_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  hjsq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hjsq_core #(
    .SampleBits (SampleBits),
    .TimerBits  (TimerBits)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .acc_i            (acc),
    .kind_i           (hjsq_pkg::kind_e'(s_axis_tuser)),
    .sample_up_i      (s_axis_tdata[SampleBits-1:0]),
    .sample_down_i    (s_axis_tdata[2*SampleBits-1:SampleBits]),
    .button_pressed_i (s_axis_tdata[2*SampleBits]),
    .event_o          (ev_d),
    .fast_mode_o      (fast_d)
  );

  assign out_valid_d = acc || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ev_q   <= ev_d;
      fast_q <= fast_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, fast_q, ev_q};

endmodule
